@@ sv/bdq_pkg.sv @@
package bdq_pkg;

    // request codes carried in the slave-side tuser
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_ERASE      = 3'd4;
    localparam logic [2:0] OP_COUNT      = 3'd5;

    // status codes carried in the master-side tuser
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] operand;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value;
        logic [6:0]  occupancy;
    } t_rslt;

endpackage

@@ sv/bdq_ram.sv @@
module bdq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/bdq_ctrl.sv @@
module bdq_ctrl
    import bdq_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  t_req                  i_req,
    output logic                  o_idle,
    output logic                  o_done,
    output t_rslt                 o_rslt,
    output logic                  o_mem_we,
    output logic [AW-1:0]         o_mem_addr,
    output logic [DATA_WIDTH-1:0] o_mem_wdata,
    input  logic [DATA_WIDTH-1:0] i_mem_rdata
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_POPRD  = 7'b0000100,
        S_SCAN   = 7'b0001000,
        S_SHRD   = 7'b0010000,
        S_SHWR   = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state                r_state, n_state;
    logic [2:0]            r_op, n_op;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic [AW-1:0]         r_head, n_head;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_idx, n_idx;
    logic [AW-1:0]         r_pos, n_pos;
    logic                  r_vld, n_vld;
    logic [CW-1:0]         r_cmp_idx, n_cmp_idx;
    logic [AW-1:0]         r_cmp_pos, n_cmp_pos;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [1:0]            r_status, n_status;
    logic [31:0]           r_value, n_value;

    logic [63:0] op_ext;
    logic [63:0] rd_ext;
    logic        full;
    logic        empty;
    logic        issue;
    logic        match;

    // ring pointer helpers
    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(CAPACITY - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(CAPACITY - 1) : p - 1'b1;
    endfunction

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [AW:0] s;
        s = {1'b0, base} + (AW + 1)'(off);
        if (s >= (AW + 1)'(CAPACITY)) begin
            s = s - (AW + 1)'(CAPACITY);
        end
        return s[AW-1:0];
    endfunction

    assign op_ext = 64'(signed'(i_req.operand));
    assign rd_ext = 64'(signed'(i_mem_rdata));
    assign full   = (r_count == CW'(CAPACITY));
    assign empty  = (r_count == '0);
    assign issue  = (r_idx != r_count);
    assign match  = r_vld && (i_mem_rdata == r_val);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_val       = r_val;
        n_head      = r_head;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_vld       = r_vld;
        n_cmp_idx   = r_cmp_idx;
        n_cmp_pos   = r_cmp_pos;
        n_cnt       = r_cnt;
        n_status    = r_status;
        n_value     = r_value;
        o_mem_we    = 1'b0;
        o_mem_addr  = r_pos;
        o_mem_wdata = r_val;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op     = i_req.op;
                    n_val    = op_ext[DATA_WIDTH-1:0];
                    n_status = ST_OK;
                    n_value  = '0;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                case (r_op)
                    OP_PUSH_FRONT: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_head     = wrap_dec(r_head);
                            o_mem_we   = 1'b1;
                            o_mem_addr = wrap_dec(r_head);
                            n_count    = r_count + 1'b1;
                        end
                    end
                    OP_PUSH_BACK: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            o_mem_we   = 1'b1;
                            o_mem_addr = ring_add(r_head, r_count);
                            n_count    = r_count + 1'b1;
                        end
                    end
                    OP_POP_FRONT: begin
                        if (empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            o_mem_addr = r_head;
                            n_state    = S_POPRD;
                        end
                    end
                    OP_POP_BACK: begin
                        if (empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            o_mem_addr = ring_add(r_head, r_count - 1'b1);
                            n_state    = S_POPRD;
                        end
                    end
                    OP_ERASE, OP_COUNT: begin
                        if (empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_idx   = '0;
                            n_pos   = r_head;
                            n_vld   = 1'b0;
                            n_cnt   = '0;
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                        // unused codes leave the store alone
                    end
                endcase
            end
            S_POPRD: begin
                n_value = rd_ext[31:0];
                n_count = r_count - 1'b1;
                if (r_op == OP_POP_FRONT) begin
                    n_head = wrap_inc(r_head);
                end
                n_state = S_DONE;
            end
            S_SCAN: begin
                // issue one read a cycle, compare the word that came back
                n_vld = issue;
                if (issue) begin
                    o_mem_addr = r_pos;
                    n_idx      = r_idx + 1'b1;
                    n_pos      = wrap_inc(r_pos);
                    n_cmp_idx  = r_idx;
                    n_cmp_pos  = r_pos;
                end
                if (match && (r_op == OP_ERASE)) begin
                    n_idx   = r_cmp_idx;
                    n_pos   = r_cmp_pos;
                    n_vld   = 1'b0;
                    n_state = S_SHRD;
                end else if (match) begin
                    n_cnt = r_cnt + 1'b1;
                end
                if (!r_vld && !issue) begin
                    if (r_op == OP_ERASE) begin
                        n_status = ST_NOTFOUND;
                    end else begin
                        n_value = 32'(r_cnt);
                    end
                    n_state = S_DONE;
                end
            end
            S_SHRD: begin
                // close the gap: fetch the entry after the hole
                if (CW'(r_idx + 1'b1) < r_count) begin
                    o_mem_addr = wrap_inc(r_pos);
                    n_state    = S_SHWR;
                end else begin
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end
            end
            S_SHWR: begin
                o_mem_we    = 1'b1;
                o_mem_addr  = r_pos;
                o_mem_wdata = i_mem_rdata;
                n_idx       = r_idx + 1'b1;
                n_pos       = wrap_inc(r_pos);
                n_state     = S_SHRD;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_vld   <= n_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_val     <= n_val;
        r_idx     <= n_idx;
        r_pos     <= n_pos;
        r_cmp_idx <= n_cmp_idx;
        r_cmp_pos <= n_cmp_pos;
        r_cnt     <= n_cnt;
        r_status  <= n_status;
        r_value   <= n_value;
    end

    assign o_idle           = (r_state == S_IDLE);
    assign o_done           = (r_state == S_DONE);
    assign o_rslt.status    = r_status;
    assign o_rslt.value     = r_value;
    assign o_rslt.occupancy = 7'(r_count);

endmodule

@@ sv/bounded_deque_with_search_top.sv @@
// Bounded double-ended queue of CAPACITY signed words held in a single-port
// RAM ring, with push and pop at either end, erase of the first entry equal
// to a value and count of entries equal to a value. Every request transaction
// gives exactly one result transaction (status, value, occupancy). The block
// takes one request at a time and is ready again once the previous result has
// left the output register. Pops fetch their entry through the RAM's registered
// read. Count scans the N held entries one entry per cycle through the single
// RAM port; erase scans the same way up to the match at position k, then closes
// the gap by a read and a write per moved entry. The store needs no clearing
// after reset: only occupied entries are ever read.
module bounded_deque_with_search_top
    import bdq_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [31:0] operand_value
    input  logic [2:0]  i_s_axis_tuser,  // [2:0] req_type
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,  // [31:0] result_value, [38:32] occupancy
    output logic [1:0]  o_m_axis_tuser   // [1:0] status
);

    localparam int AW = $clog2(CAPACITY);

    t_req                  req;
    t_rslt                 rslt;
    t_rslt                 r_out;
    logic                  r_out_valid;
    logic                  ctrl_idle;
    logic                  ctrl_done;
    logic                  start;
    logic                  mem_we;
    logic [AW-1:0]         mem_addr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [DATA_WIDTH-1:0] mem_rdata;

    assign req.op          = i_s_axis_tuser;
    assign req.operand     = i_s_axis_tdata;
    assign o_s_axis_tready = ctrl_idle && !r_out_valid;
    assign start           = i_s_axis_tvalid && o_s_axis_tready;

    bdq_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (req),
        .o_idle      (ctrl_idle),
        .o_done      (ctrl_done),
        .o_rslt      (rslt),
        .o_mem_we    (mem_we),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata),
        .i_mem_rdata (mem_rdata)
    );

    bdq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // output register: holds a result until the master side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl_done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl_done) begin
            r_out <= rslt;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out.occupancy, r_out.value};
    assign o_m_axis_tuser  = r_out.status;

endmodule

@@ dv/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bdq_pkg::*;

    localparam int CAP         = 64;
    localparam int N_RANDOM    = 1050;
    localparam int QUIET_TAIL  = 120;
    localparam int CYCLE_LIMIT = 1_200_000;

    // request codes the block ignores
    localparam logic [2:0] OP_RSVD_6 = 3'd6;
    localparam logic [2:0] OP_RSVD_7 = 3'd7;

    typedef enum {PH_FILL, PH_DRAIN, PH_MIXED, PH_SEARCH} t_phase;

    // Deque predictor plus the queue of results it still owes
    class deque_scoreboard;
        logic [31:0] ring [CAP];
        logic [5:0]  head;
        int          held;
        t_rslt       owed [$];
        int          fails;

        function new();
            head  = '0;
            held  = 0;
            fails = 0;
        endfunction

        function logic [5:0] slot(int idx);
            return head + 6'(idx);
        endfunction

        function logic [31:0] entry_at(int idx);
            return ring[slot(idx)];
        endfunction

        // Apply one accepted request transaction and queue its result
        function void note_request(logic [2:0] op, logic [31:0] operand);
            t_rslt r;
            int    hit;
            r.status = ST_OK;
            r.value  = '0;
            case (op)
                OP_PUSH_FRONT, OP_PUSH_BACK: begin
                    if (held >= CAP) begin
                        r.status = ST_FULL;
                    end else if (op == OP_PUSH_FRONT) begin
                        head       = head - 6'd1;
                        ring[head] = operand;
                        held++;
                    end else begin
                        ring[slot(held)] = operand;
                        held++;
                    end
                end
                OP_POP_FRONT: begin
                    if (held == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.value = ring[head];
                        head    = head + 6'd1;
                        held--;
                    end
                end
                OP_POP_BACK: begin
                    if (held == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.value = ring[slot(held - 1)];
                        held--;
                    end
                end
                OP_ERASE: begin
                    if (held == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        hit = -1;
                        for (int i = 0; i < held && hit < 0; i++)
                            if (ring[slot(i)] == operand) hit = i;
                        if (hit < 0) begin
                            r.status = ST_NOTFOUND;
                        end else begin
                            // later entries close the gap
                            for (int j = hit; j + 1 < held; j++)
                                ring[slot(j)] = ring[slot(j + 1)];
                            held--;
                        end
                    end
                end
                OP_COUNT: begin
                    if (held == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        for (int i = 0; i < held; i++)
                            if (ring[slot(i)] == operand) r.value = r.value + 32'd1;
                    end
                end
                default: ;
            endcase
            r.occupancy = 7'(held);
            owed.push_back(r);
        endfunction

        // Compare one result transaction against the oldest owed result
        function void check_result(logic [1:0] status, logic [39:0] data);
            t_rslt want;
            if (owed.size() == 0) begin
                $error("result with nothing owed: status %0d data %h", status, data);
                fails++;
                return;
            end
            want = owed.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                fails++;
            end
            if (data[31:0] !== want.value) begin
                $error("result_value: expected %h, got %h", want.value, data[31:0]);
                fails++;
            end
            if (data[38:32] !== want.occupancy) begin
                $error("occupancy: expected %0d, got %0d", want.occupancy, data[38:32]);
                fails++;
            end
            if (data[39] !== 1'b0) begin
                $error("tdata pad: expected 0, got %b", data[39]);
                fails++;
            end
        endfunction
    endclass

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata  = '0;   // [31:0] operand_value
    logic [2:0]  s_tuser  = '0;   // [2:0] req_type
    logic        m_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [39:0] o_m_axis_tdata;  // [31:0] result_value, [38:32] occupancy
    logic [1:0]  o_m_axis_tuser;  // [1:0] status

    deque_scoreboard sb;
    int          snd_gap_pct  = 0;
    int          rcv_stall_pct = 0;
    int          stall_left   = 0;
    int unsigned cycles       = 0;

    bounded_deque_with_search_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // run guard
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL bounded_deque_with_search_top");
            $finish;
        end
    end

    // receiver backpressure in bursts
    always @(posedge i_clk) begin
        if (stall_left == 0 && rcv_stall_pct > 0 && $urandom_range(0, 99) < rcv_stall_pct)
            stall_left = $urandom_range(1, 11);
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_tready)
            sb.check_result(o_m_axis_tuser, o_m_axis_tdata);
    end

    // Drive one request transaction, with an optional idle burst ahead of it
    task automatic send_req(logic [2:0] op, logic [31:0] operand);
        int gap;
        gap = 0;
        if (snd_gap_pct > 0 && $urandom_range(0, 99) < snd_gap_pct)
            gap = $urandom_range(1, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= operand;
        s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_request(op, operand);
    endtask

    // Hold off the sender until every owed result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.owed.size() != 0);
    endtask

    function automatic logic [2:0] pick_op(t_phase ph);
        int r;
        int t_push, t_pop, t_erase;
        r = $urandom_range(0, 99);
        if (r < 2) return (r == 0) ? OP_RSVD_6 : OP_RSVD_7;
        case (ph)
            PH_FILL:  begin t_push = 70; t_pop = 85; t_erase = 93; end
            PH_DRAIN: begin t_push = 15; t_pop = 80; t_erase = 90; end
            PH_MIXED: begin t_push = 35; t_pop = 65; t_erase = 83; end
            default:  begin t_push = 25; t_pop = 40; t_erase = 70; end
        endcase
        r = $urandom_range(0, 99);
        if (r < t_push)  return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        if (r < t_pop)   return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
        if (r < t_erase) return OP_ERASE;
        return OP_COUNT;
    endfunction

    // small pool for duplicates, held values for hits, extremes, full range
    function automatic logic [31:0] pick_operand();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 32'($urandom_range(0, 8)) - 32'd4;
        if (r < 70 && sb.held > 0) return sb.entry_at($urandom_range(0, sb.held - 1));
        if (r < 80) begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'hffff_ffff;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom;
    endfunction

    initial begin
        int          n_done;
        int          phase_left;
        int          bound_hits;
        bit          phase_over;
        t_phase      phase;
        logic [2:0]  op;
        logic [31:0] val;

        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty-store cases, ignored codes, extremes, ring wrap
        snd_gap_pct   = 20;
        rcv_stall_pct = 15;
        send_req(OP_POP_FRONT,  32'hdead_beef);
        send_req(OP_POP_BACK,   32'h0000_0000);
        send_req(OP_ERASE,      32'h0000_0001);
        send_req(OP_COUNT,      32'h0000_0001);
        send_req(OP_RSVD_6,     32'hffff_ffff);
        send_req(OP_PUSH_FRONT, 32'h8000_0000);
        send_req(OP_PUSH_BACK,  32'h7fff_ffff);
        send_req(OP_PUSH_FRONT, 32'hffff_ffff);
        send_req(OP_PUSH_BACK,  32'h0000_0000);
        send_req(OP_COUNT,      32'h7fff_ffff);
        send_req(OP_ERASE,      32'h0000_0005);
        send_req(OP_ERASE,      32'h8000_0000);
        send_req(OP_RSVD_7,     32'h1234_5678);
        send_req(OP_PUSH_BACK,  32'h0000_0005);
        send_req(OP_PUSH_BACK,  32'h0000_0005);
        send_req(OP_COUNT,      32'h0000_0005);
        send_req(OP_ERASE,      32'h0000_0005);
        send_req(OP_POP_BACK,   32'hffff_ffff);
        send_req(OP_POP_FRONT,  32'h0000_0000);
        send_req(OP_POP_FRONT,  32'h0000_0000);
        send_req(OP_POP_BACK,   32'h0000_0000);
        send_req(OP_POP_BACK,   32'h0000_0000);
        wait_drained();

        // random: phases that fill to full, drain to empty, mix, or search
        n_done     = 0;
        phase      = PH_FILL;
        phase_left = 200;
        bound_hits = 0;
        while (n_done < N_RANDOM) begin
            case (phase)
                PH_FILL:  phase_over = (sb.held == CAP && bound_hits >= 2) || phase_left == 0;
                PH_DRAIN: phase_over = (sb.held == 0 && bound_hits >= 2) || phase_left == 0;
                default:  phase_over = (phase_left == 0);
            endcase
            if (phase_over) begin
                phase      = t_phase'($urandom_range(0, 3));
                phase_left = (phase == PH_FILL || phase == PH_DRAIN) ? 200
                                                                     : $urandom_range(30, 90);
                bound_hits = 0;
                if ($urandom_range(0, 3) == 0) begin
                    snd_gap_pct   = 0;
                    rcv_stall_pct = 0;
                end else begin
                    snd_gap_pct   = 25;
                    rcv_stall_pct = 20;
                end
                if ($urandom_range(0, 2) == 0) wait_drained();
            end
            // last stretch runs at full rate
            if (N_RANDOM - n_done <= QUIET_TAIL) begin
                snd_gap_pct   = 0;
                rcv_stall_pct = 0;
            end

            op  = pick_op(phase);
            val = pick_operand();
            if ((op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && sb.held == CAP) bound_hits++;
            if ((op == OP_POP_FRONT || op == OP_POP_BACK) && sb.held == 0) bound_hits++;
            send_req(op, val);
            phase_left--;
            if (op <= OP_COUNT) n_done++;
        end

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (sb.fails == 0 && sb.owed.size() == 0) begin
            $display("PASS bounded_deque_with_search_top");
        end else begin
            $display("FAIL bounded_deque_with_search_top");
        end
        $finish;
    end

endmodule
